// ===== rtl/msr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msr_pkg
// Shared constants, register codes and the sigmoid table builder for the
// sigmoid top-k expert router.
// ----------------------------------------------------------------------------
package msr_pkg;

	// default sizes
	localparam int MAX_EXPERTS_DEF = 256;
	localparam int MAX_PICKS_DEF   = 16;

	// sigmoid table geometry
	localparam int SIG_ENTRIES = 1024;
	localparam int SIG_AW      = $clog2(SIG_ENTRIES);
	localparam int SIG_STEP    = 65536 / SIG_ENTRIES;

	// datapath widths
	localparam int PROB_W  = 16;
	localparam int SCORE_W = 18;
	localparam int ACC_W   = 48;
	localparam int PROD_W  = 32;
	localparam int NUM_W   = 37;
	localparam int OUT_W   = 24;

	// register map
	localparam int PADDR_W = 5;
	typedef enum logic [2:0] {
		REG_EXPERT_COUNT = 3'd0,
		REG_PICKS        = 3'd1,
		REG_BIAS_EN      = 3'd2,
		REG_NORM_EN      = 3'd3,
		REG_SCALE        = 3'd4
	} reg_idx_t;

	// register reset values
	localparam logic [8:0]  EXPERT_COUNT_RST = 9'd8;
	localparam logic [4:0]  PICKS_RST        = 5'd2;
	localparam logic        BIAS_EN_RST      = 1'b0;
	localparam logic        NORM_EN_RST      = 1'b1;
	localparam logic [15:0] SCALE_RST        = 16'd4096;

	typedef logic [PROB_W-1:0] sig_tbl_t [SIG_ENTRIES];

	// shift and subtract quotient, table quotients stay below 2^18
	function automatic longint unsigned sig_udiv(input longint unsigned num,
		input longint unsigned den);
		longint unsigned r;
		longint unsigned q;
		r = num;
		q = 0;
		for (int s = 17; s >= 0; s--) begin
			if (r >= (den << s)) begin
				r = r - (den << s);
				q = q | (64'd1 << s);
			end
		end
		return q;
	endfunction

	// sigmoid table, Q0.16, entry i at x = -8 + i*16/SIG_ENTRIES
	function automatic sig_tbl_t sig_tbl_build();
		longint unsigned c [16];
		longint unsigned t;
		longint unsigned d;
		longint unsigned p;
		int x;
		int a;
		sig_tbl_t tb;
		c[0] = 64'd4293918848;
		for (int b = 1; b < 16; b++) begin
			c[b] = (c[b-1] * c[b-1] + 64'h8000_0000) >> 32;
		end
		for (int i = 0; i < SIG_ENTRIES; i++) begin
			x = i * SIG_STEP - 32768;
			a = (x < 0) ? -x : x;
			t = 64'h1_0000_0000;
			for (int b = 0; b < 16; b++) begin
				if (((a >> b) & 1) != 0) begin
					t = (t * c[b] + 64'h8000_0000) >> 32;
				end
			end
			d = 64'h1_0000_0000 + t;
			if (x >= 0) begin
				p = sig_udiv((64'h1 << 48) + (d >> 1), d);
				if (p > 64'd65535) begin
					p = 64'd65535;
				end
			end else begin
				p = sig_udiv((t << 16) + (d >> 1), d);
			end
			tb[i] = p[PROB_W-1:0];
		end
		return tb;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/msr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module msr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/msr_sig_rom.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msr_sig_rom
// Sigmoid lookup table with registered read, Q0.16 output.
// ----------------------------------------------------------------------------
module msr_sig_rom (
	input  wire logic                        clk,
	input  wire logic [msr_pkg::SIG_AW-1:0]  addr,
	output logic      [msr_pkg::PROB_W-1:0]  data
);

	localparam msr_pkg::sig_tbl_t TBL = msr_pkg::sig_tbl_build();

	// registered table read
	always_ff @(posedge clk) begin
		data <= TBL[addr];
	end

endmodule
`default_nettype wire

// ===== rtl/msr_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msr_div #(
	parameter int NW = 37,
	parameter int DW = 21
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic      [NW-1:0] quo
);

	localparam int CNTW = $clog2(NW + 1);

	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   den_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic [DW:0]     rem_sh;
	logic [DW+1:0]   diff;
	logic            ge;

	// one trial subtraction
	assign rem_sh = {rem_q, quo[NW-1]};
	assign diff   = {1'b0, rem_sh} - {2'b0, den_q};
	assign ge     = ~diff[DW+1];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNTW'(NW - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath: numerator shifts out as quotient shifts in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo   <= num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
			quo   <= {quo[NW-2:0], ge};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/moe_sigmoid_topk_router_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// moe_sigmoid_topk_router_core
// Non-ending terms: one word per cycle, set by the multiply and accumulate.
// Ending term: accept, product, table read, store and compare, insert.
// Row end: read and add per pick to sum, then per result read, scale,
// weight step, bit-serial divide when normalizing, and output wait.
// Reset clears control, counters and config registers, not data or memories.
// ----------------------------------------------------------------------------
module moe_sigmoid_topk_router_core #(
	parameter int MAX_EXPERTS = msr_pkg::MAX_EXPERTS_DEF,
	parameter int MAX_PICKS   = msr_pkg::MAX_PICKS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [msr_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [15:0]            hidden_value,
	input  wire logic signed [15:0]            weight_value,
	input  wire logic signed [15:0]            score_bias,
	input  wire logic                          last_term,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [7:0]                    expert_index,
	output logic      [msr_pkg::OUT_W-1:0]     routing_weight,
	output logic                               last_of_row
);

	localparam int AW   = $clog2(MAX_EXPERTS);
	localparam int CW   = $clog2(MAX_EXPERTS + 1);
	localparam int KW   = $clog2(MAX_PICKS + 1);
	localparam int PIW  = (MAX_PICKS > 1) ? $clog2(MAX_PICKS) : 1;
	localparam int PW   = msr_pkg::PROB_W;
	localparam int SW   = msr_pkg::PROB_W + KW;
	localparam int NW   = msr_pkg::NUM_W;
	localparam int SCW  = msr_pkg::SCORE_W;
	localparam int ACW  = msr_pkg::ACC_W;
	localparam int OW   = msr_pkg::OUT_W;
	localparam int SAW  = msr_pkg::SIG_AW;

	typedef enum logic [10:0] {
		ST_ACC   = 11'b000_0000_0001,
		ST_LOOK  = 11'b000_0000_0010,
		ST_PROB  = 11'b000_0000_0100,
		ST_INS   = 11'b000_0000_1000,
		ST_SRD   = 11'b000_0001_0000,
		ST_SACC  = 11'b000_0010_0000,
		ST_WRD   = 11'b000_0100_0000,
		ST_WMUL  = 11'b000_1000_0000,
		ST_WCALC = 11'b001_0000_0000,
		ST_WDIV  = 11'b010_0000_0000,
		ST_OUT   = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [8:0]  ec_q;
	logic [4:0]  k_q;
	logic        bias_en_q;
	logic        norm_en_q;
	logic [15:0] scale_q;
	logic        cfg_wr;
	msr_pkg::reg_idx_t cfg_idx;

	// term pipeline
	logic                    valid_s1;
	logic                    last_s1;
	logic signed [31:0]      prod_s1;
	logic signed [15:0]      bias_s1;
	logic [ACW-1:0]          acc_q;
	logic [ACW-1:0]          acc_fin_q;
	logic signed [15:0]      bias_q;

	// logit and table
	logic signed [15:0]      logit;
	logic [15:0]             logit_u;
	logic [31:0]             idx_prod;
	logic [SAW-1:0]          rom_addr;
	logic [PW-1:0]           rom_data;

	// top-k list
	logic signed [SCW-1:0]   best_s_q [MAX_PICKS];
	logic [AW-1:0]           best_i_q [MAX_PICKS];
	logic signed [SCW-1:0]   s_prev   [MAX_PICKS];
	logic [AW-1:0]           i_prev   [MAX_PICKS];
	logic [MAX_PICKS-1:0]    le_c;
	logic [MAX_PICKS-1:0]    le_q;
	logic [MAX_PICKS-1:0]    le_prev;
	logic signed [SCW-1:0]   score_c;
	logic signed [SCW-1:0]   score_q;
	logic [KW-1:0]           fill_q;
	logic [KW-1:0]           fill_eff;
	logic [KW-1:0]           fill_new;
	logic [CW-1:0]           cnt_q;
	logic [CW-1:0]           cnt_nxt;
	logic [CW-1:0]           e_eff;
	logic [KW-1:0]           k_eff;
	int                      k_int;

	// emission
	logic [KW-1:0]           n_q;
	logic [KW-1:0]           ei_q;
	logic [KW-1:0]           ei_nxt;
	logic [SW-1:0]           sum_q;
	logic [msr_pkg::PROD_W-1:0] prod_w_q;
	logic [PW-1:0]           ram_rdata;
	logic [NW-1:0]           div_num;
	logic [NW-1:0]           div_quo;
	logic                    div_start;
	logic                    div_done;
	logic [32:0]             plain_sum;
	logic [20:0]             plain_w;

	// apb port
	assign pready  = 1'b1;
	assign cfg_idx = msr_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ec_q      <= msr_pkg::EXPERT_COUNT_RST;
			k_q       <= msr_pkg::PICKS_RST;
			bias_en_q <= msr_pkg::BIAS_EN_RST;
			norm_en_q <= msr_pkg::NORM_EN_RST;
			scale_q   <= msr_pkg::SCALE_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				msr_pkg::REG_EXPERT_COUNT: ec_q      <= pwdata[8:0];
				msr_pkg::REG_PICKS:        k_q       <= pwdata[4:0];
				msr_pkg::REG_BIAS_EN:      bias_en_q <= pwdata[0];
				msr_pkg::REG_NORM_EN:      norm_en_q <= pwdata[0];
				msr_pkg::REG_SCALE:        scale_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			msr_pkg::REG_EXPERT_COUNT: prdata = {23'd0, ec_q};
			msr_pkg::REG_PICKS:        prdata = {27'd0, k_q};
			msr_pkg::REG_BIAS_EN:      prdata = {31'd0, bias_en_q};
			msr_pkg::REG_NORM_EN:      prdata = {31'd0, norm_en_q};
			msr_pkg::REG_SCALE:        prdata = {16'd0, scale_q};
			default:                   prdata = '0;
		endcase
	end

	// effective expert count and picks
	always_comb begin
		if (ec_q == '0) begin
			e_eff = CW'(1);
		end else if (int'(ec_q) > MAX_EXPERTS) begin
			e_eff = CW'(MAX_EXPERTS);
		end else begin
			e_eff = CW'(ec_q);
		end
		k_int = int'(k_q);
		if (k_int == 0) begin
			k_int = 1;
		end
		if (k_int > MAX_PICKS) begin
			k_int = MAX_PICKS;
		end
		if (k_int > int'(e_eff)) begin
			k_int = int'(e_eff);
		end
		k_eff = KW'(k_int);
	end

	assign fill_eff = (fill_q > k_eff) ? k_eff : fill_q;
	assign fill_new = (fill_eff < k_eff) ? fill_eff + 1'b1 : k_eff;
	assign cnt_nxt  = cnt_q + 1'b1;
	assign ei_nxt   = ei_q + 1'b1;

	// input word handshake
	assign in_ready = (state_q == ST_ACC) && !(valid_s1 && last_s1);

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			prod_s1 <= hidden_value * weight_value;
			last_s1 <= last_term;
			bias_s1 <= score_bias;
		end
	end

	// logit: floor shift, saturate, table index
	always_comb begin
		if (acc_fin_q[ACW-1:27] == '0 || acc_fin_q[ACW-1:27] == '1) begin
			logit = acc_fin_q[27:12];
		end else if (acc_fin_q[ACW-1]) begin
			logit = 16'sh8000;
		end else begin
			logit = 16'sh7fff;
		end
		logit_u  = {~logit[15], logit[14:0]};
		idx_prod = 32'(logit_u) * 32'(msr_pkg::SIG_ENTRIES);
		rom_addr = idx_prod[16 +: SAW];
	end

	msr_sig_rom u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	// score and insert position
	always_comb begin
		if (bias_en_q) begin
			score_c = SCW'($signed({1'b0, rom_data[PW-1:4]})) + SCW'(bias_q);
		end else begin
			score_c = SCW'($signed({1'b0, rom_data}));
		end
		for (int j = 0; j < MAX_PICKS; j++) begin
			le_c[j] = (KW'(j) < fill_eff) && !(score_c > best_s_q[j]);
		end
		le_prev[0] = 1'b1;
		s_prev[0]  = best_s_q[0];
		i_prev[0]  = best_i_q[0];
		for (int j = 1; j < MAX_PICKS; j++) begin
			le_prev[j] = le_q[j-1];
			s_prev[j]  = best_s_q[j-1];
			i_prev[j]  = best_i_q[j-1];
		end
	end

	// sorted insert, ties keep the earlier expert
	always_ff @(posedge clk) begin
		if (state_q == ST_INS) begin
			for (int j = 0; j < MAX_PICKS; j++) begin
				if (KW'(j) < k_eff && !le_q[j]) begin
					if (le_prev[j]) begin
						best_s_q[j] <= score_q;
						best_i_q[j] <= cnt_q[AW-1:0];
					end else begin
						best_s_q[j] <= s_prev[j];
						best_i_q[j] <= i_prev[j];
					end
				end
			end
		end
	end

	// probability store
	msr_ram #(
		.WIDTH (PW),
		.DEPTH (MAX_EXPERTS)
	) u_prob_ram (
		.clk   (clk),
		.we    (state_q == ST_PROB),
		.waddr (cnt_q[AW-1:0]),
		.wdata (rom_data),
		.raddr (best_i_q[ei_q[PIW-1:0]]),
		.rdata (ram_rdata)
	);

	// routing weight arithmetic
	assign div_num   = NW'({prod_w_q, 4'b0000}) + NW'(sum_q >> 1);
	assign div_start = (state_q == ST_WCALC) && norm_en_q && (sum_q != '0);
	assign plain_sum = {1'b0, prod_w_q} + 33'd2048;
	assign plain_w   = plain_sum[32:12];

	msr_div #(
		.NW (NW),
		.DW (SW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (sum_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_ACC && valid_s1 && last_s1) begin
			acc_fin_q <= acc_q + ACW'(prod_s1);
			bias_q    <= bias_s1;
		end
		if (state_q == ST_PROB) begin
			score_q <= score_c;
			le_q    <= le_c;
		end
		if (state_q == ST_WMUL) begin
			prod_w_q <= ram_rdata * scale_q;
		end
		if (state_q == ST_WCALC) begin
			expert_index <= 8'(best_i_q[ei_q[PIW-1:0]]);
			last_of_row  <= (ei_nxt == n_q);
			if (!norm_en_q) begin
				routing_weight <= OW'(plain_w);
			end else if (sum_q == '0) begin
				routing_weight <= '0;
			end
		end
		if (state_q == ST_WDIV && div_done) begin
			routing_weight <= (div_quo[NW-1:OW] != '0) ? '1 : div_quo[OW-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			acc_q   <= '0;
			cnt_q   <= '0;
			fill_q  <= '0;
			n_q     <= '0;
			ei_q    <= '0;
			sum_q   <= '0;
		end else begin
			unique case (state_q)
				ST_ACC: begin
					if (valid_s1) begin
						if (last_s1) begin
							acc_q   <= '0;
							state_q <= ST_LOOK;
						end else begin
							acc_q <= acc_q + ACW'(prod_s1);
						end
					end
				end
				ST_LOOK: state_q <= ST_PROB;
				ST_PROB: state_q <= ST_INS;
				ST_INS: begin
					if (cnt_nxt >= e_eff) begin
						n_q     <= fill_new;
						cnt_q   <= '0;
						fill_q  <= '0;
						ei_q    <= '0;
						sum_q   <= '0;
						state_q <= ST_SRD;
					end else begin
						cnt_q   <= cnt_nxt;
						fill_q  <= fill_new;
						state_q <= ST_ACC;
					end
				end
				ST_SRD: state_q <= ST_SACC;
				ST_SACC: begin
					sum_q <= sum_q + SW'(ram_rdata);
					if (ei_nxt == n_q) begin
						ei_q    <= '0;
						state_q <= ST_WRD;
					end else begin
						ei_q    <= ei_nxt;
						state_q <= ST_SRD;
					end
				end
				ST_WRD:  state_q <= ST_WMUL;
				ST_WMUL: state_q <= ST_WCALC;
				ST_WCALC: begin
					state_q <= div_start ? ST_WDIV : ST_OUT;
				end
				ST_WDIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						if (last_of_row) begin
							state_q <= ST_ACC;
						end else begin
							ei_q    <= ei_nxt;
							state_q <= ST_WRD;
						end
					end
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

	assign out_valid = (state_q == ST_OUT);

endmodule
`default_nettype wire

// ===== rtl/msr_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msr_chk
// Port-level checks for the router core, bound to the top level.
// ----------------------------------------------------------------------------
module msr_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        last_term,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  expert_index,
	input wire logic [23:0] routing_weight,
	input wire logic        last_of_row
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(expert_index)
		&& $stable(routing_weight) && $stable(last_of_row))
		else $error("result word changed while stalled");

	// input and output sides never open together
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready during result output");

	// an ending term closes the input for the next cycle
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_term |=> !in_ready)
		else $error("input ready right after ending term");

	// the last word of a row is followed by no result
	a_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_of_row |=> !out_valid)
		else $error("result word after end of row");

endmodule

bind moe_sigmoid_topk_router_core msr_chk u_msr_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.last_term      (last_term),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.expert_index   (expert_index),
	.routing_weight (routing_weight),
	.last_of_row    (last_of_row)
);
`default_nettype wire
